// ----- sv/highpass_saturation_exciter_macros.svh -----
// assertion macros used by the exciter controller
`ifndef HIGHPASS_SATURATION_EXCITER_MACROS_SVH
`define HIGHPASS_SATURATION_EXCITER_MACROS_SVH

`ifndef SYNTHESIS
`define HSE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("exciter assertion failed");
`define HSE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("exciter assertion failed");
`else
`define HSE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HSE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- sv/hse_pkg.sv -----
// types, constants and arithmetic helpers of the exciter
`default_nettype none
package hse_pkg;

  localparam int unsigned REG_ENABLE = 0;
  localparam int unsigned REG_B0     = 1;
  localparam int unsigned REG_A1     = 2;
  localparam int unsigned REG_A2     = 3;
  localparam int unsigned REG_DRIVE  = 4;
  localparam int unsigned REG_WET    = 5;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIV_STEPS  = 25;
  localparam int unsigned CNT_W      = 5;

  localparam logic       OPC_PROCESS = 1'b0;
  localparam logic       OPC_CLEAR   = 1'b1;

  localparam logic signed [67:0] LIM_Q23   = 68'sd25165824;
  localparam logic        [28:0] K27_Q23   = 29'd226492416;
  localparam logic signed [25:0] ONE_Q23   = 26'sd8388608;
  localparam logic        [16:0] WET_ONE   = 17'd65536;

  typedef enum logic [3:0] {
    OP_NONE, OP_BX, OP_HP, OP_A1, OP_Z1, OP_Z2, OP_D, OP_DD,
    OP_X2, OP_NUM, OP_DIVI, OP_DIV, OP_E, OP_DRY, OP_WET, OP_MIX
  } dp_op_t;

  typedef struct packed {
    logic   load;
    logic   emit;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic proc;
    logic clip;
  } dp_stat_t;

  function automatic logic signed [67:0] rnd_shr(input logic signed [67:0] v,
                                                 input int unsigned s);
    logic signed [67:0] t;
    t = v + (68'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7fffffff;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [67:0] v);
    logic signed [23:0] r;
    if (v > 68'sd8388607) r = 24'sh7fffff;
    else if (v < -68'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/highpass_saturation_exciter.sv -----
// top level of the high-pass saturation exciter
//
//  port group   dir  tdata               tuser
//  in_          in   sample_in[23:0]     opcode[0], channel[1]
//  out_         out  sample_out[23:0]    -
//  cfg_         in   write data [31:0]   index [2:0]
//
// a processed sample runs through the filter, drive, curve, divide and mix steps in order;
// the curve and divide steps are skipped when the driven value clips
// pass-through and clear beats go straight from the accepting state to the done state
// the divider gives one quotient bit a cycle; the 33x33 multiplier is shared by the steps
// reset is synchronous, active low; it clears the delay state of every channel
// one item is in flight at a time; a finished result waits in the output
// register while the next beat is accepted
`default_nettype none
module highpass_saturation_exciter import hse_pkg::*; #(
  parameter int MAX_CHANNELS = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [23:0]           in_tdata,   // sample_in
  input  wire logic [1:0]            in_tuser,   // opcode, channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [23:0]                out_tdata   // sample_out
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  hse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .stat      (stat),
    .cmd       (cmd)
  );

  hse_dp #(.MAX_CHANNELS(MAX_CHANNELS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_user   (in_tuser),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_tdata)
  );

endmodule
`default_nettype wire

// ----- sv/hse_dp.sv -----
// datapath: config registers, delay state, shared multiplier, divider, mixer
`default_nettype none
module hse_dp import hse_pkg::*; #(
  parameter int MAX_CHANNELS = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [1:0]            in_user,
  input  wire logic [23:0]           in_data,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  output logic [23:0]                out_data
);

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic               enable_r;
  logic signed [31:0] b0_r, a1_r, a2_r;
  logic        [23:0] drive_r;
  logic        [16:0] wet_r;

  logic signed [31:0] dly1_r [MAX_CHANNELS];
  logic signed [31:0] dly2_r [MAX_CHANNELS];

  logic signed [23:0] x_r;
  logic [CH_W-1:0]    ch_r;
  logic signed [65:0] prod_r;
  logic signed [55:0] bx_r;
  logic signed [31:0] hp_r, z1n_r;
  logic signed [25:0] d_r, e_r;
  logic        [26:0] x2_r;
  logic        [29:0] den_r;
  logic        [53:0] rem_r, dsh_r;
  logic        [24:0] q_r;
  logic               neg_r;
  logic signed [43:0] acc_r;
  logic signed [23:0] res_r, out_r;

  logic signed [32:0] ma, mb;
  logic               mul_en;
  logic signed [67:0] p68, dd, x2w, mixw;
  logic signed [31:0] hp_nxt, z1_nxt, z2_nxt;
  logic        [16:0] wet, dry;
  logic        [28:0] numk;
  logic        [65:0] mag;
  logic               clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      b0_r     <= 32'sd268435456;
      a1_r     <= '0;
      a2_r     <= '0;
      drive_r  <= 24'd65536;
      wet_r    <= '0;
    end else if (cfg_we) begin
      case (32'(cfg_index))
        REG_ENABLE: enable_r <= cfg_wdata[0];
        REG_B0:     b0_r     <= cfg_wdata;
        REG_A1:     a1_r     <= cfg_wdata;
        REG_A2:     a2_r     <= cfg_wdata;
        REG_DRIVE:  drive_r  <= cfg_wdata[23:0];
        REG_WET:    wet_r    <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  assign wet  = (wet_r > WET_ONE) ? WET_ONE : wet_r;
  assign dry  = WET_ONE - wet;
  assign numk = K27_Q23 + 29'(x2_r);

  always_comb begin
    ma     = '0;
    mb     = '0;
    mul_en = 1'b1;
    unique case (cmd.op)
      OP_BX:  begin ma = 33'(b0_r); mb = 33'(x_r); end
      OP_A1:  begin ma = 33'(a1_r); mb = 33'(hp_r); end
      OP_Z1:  begin ma = 33'(a2_r); mb = 33'(hp_r); end
      OP_Z2:  begin ma = 33'(hp_r); mb = signed'({9'b0, drive_r}); end
      OP_DD:  begin ma = 33'(d_r);  mb = 33'(d_r); end
      OP_NUM: begin ma = 33'(d_r);  mb = signed'({4'b0, numk}); end
      OP_DRY: begin ma = 33'(x_r);  mb = signed'({16'b0, dry}); end
      OP_WET: begin ma = 33'(e_r);  mb = signed'({16'b0, wet}); end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= ma * mb;
  end

  assign p68    = 68'(prod_r);
  assign hp_nxt = sat32(rnd_shr(p68, 28) + 68'(dly1_r[ch_r]));
  assign z1_nxt = sat32(rnd_shr(-(68'(bx_r) <<< 1) - p68, 28) + 68'(dly2_r[ch_r]));
  assign z2_nxt = sat32(rnd_shr(68'(bx_r) - p68, 28));
  assign dd     = rnd_shr(p68, 16);
  assign clip   = (dd > LIM_Q23) || (dd < -LIM_Q23);
  assign x2w    = rnd_shr(p68, 23);
  assign mixw   = rnd_shr(68'(acc_r) + p68, 16);
  assign mag    = prod_r[65] ? 66'(-prod_r) : 66'(prod_r);

  assign stat.proc = enable_r && (in_user[0] == OPC_PROCESS) &&
                     (32'(in_user[1]) < MAX_CHANNELS);
  assign stat.clip = clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        dly1_r[i] <= '0;
        dly2_r[i] <= '0;
      end
    end else if (cmd.load && in_user[0] == OPC_CLEAR) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        dly1_r[i] <= '0;
        dly2_r[i] <= '0;
      end
    end else if (cmd.op == OP_Z2) begin
      dly1_r[ch_r] <= z1n_r;
      dly2_r[ch_r] <= z2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= in_data;
      ch_r  <= CH_W'(in_user[1]);
      res_r <= (in_user[0] == OPC_CLEAR) ? 24'sd0 : in_data;
    end
    if (cmd.emit) out_r <= res_r;
    unique case (cmd.op)
      OP_HP: begin
        bx_r <= prod_r[55:0];
        hp_r <= hp_nxt;
      end
      OP_Z1: z1n_r <= z1_nxt;
      OP_D: begin
        d_r <= dd[25:0];
        if (clip) e_r <= dd[67] ? -ONE_Q23 : ONE_Q23;
      end
      OP_X2: begin
        x2_r  <= x2w[26:0];
        den_r <= K27_Q23 + 30'(x2w[26:0]) + (30'(x2w[26:0]) << 3);
      end
      OP_DIVI: begin
        rem_r <= mag[53:0];
        neg_r <= prod_r[65];
        dsh_r <= 54'(den_r) << (DIV_STEPS - 1);
        q_r   <= '0;
      end
      OP_DIV: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[23:0], 1'b1};
        end else begin
          q_r   <= {q_r[23:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
      end
      OP_E:   e_r   <= neg_r ? -signed'({1'b0, q_r}) : signed'({1'b0, q_r});
      OP_WET: acc_r <= prod_r[43:0];
      OP_MIX: res_r <= sat24(mixw);
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

// ----- sv/hse_ctrl.sv -----
// controller: sequences the datapath steps and owns the handshakes
`default_nettype none
`include "highpass_saturation_exciter_macros.svh"
module hse_ctrl import hse_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     out_ready,
  output logic          out_valid,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001, S_BX  = 17'h00002, S_HP   = 17'h00004, S_A1  = 17'h00008,
    S_Z1   = 17'h00010, S_Z2  = 17'h00020, S_D    = 17'h00040, S_DD  = 17'h00080,
    S_X2   = 17'h00100, S_NUM = 17'h00200, S_DIVI = 17'h00400, S_DIV = 17'h00800,
    S_E    = 17'h01000, S_DRY = 17'h02000, S_WET  = 17'h04000, S_MIX = 17'h08000,
    S_DONE = 17'h10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.proc ? S_BX : S_DONE;
        end
      end
      S_BX:  begin cmd.op = OP_BX; state_nxt = S_HP; end
      S_HP:  begin cmd.op = OP_HP; state_nxt = S_A1; end
      S_A1:  begin cmd.op = OP_A1; state_nxt = S_Z1; end
      S_Z1:  begin cmd.op = OP_Z1; state_nxt = S_Z2; end
      S_Z2:  begin cmd.op = OP_Z2; state_nxt = S_D; end
      S_D:   begin cmd.op = OP_D; state_nxt = stat.clip ? S_DRY : S_DD; end
      S_DD:  begin cmd.op = OP_DD; state_nxt = S_X2; end
      S_X2:  begin cmd.op = OP_X2; state_nxt = S_NUM; end
      S_NUM: begin cmd.op = OP_NUM; state_nxt = S_DIVI; end
      S_DIVI: begin
        cmd.op    = OP_DIVI;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = S_E;
      end
      S_E:   begin cmd.op = OP_E; state_nxt = S_DRY; end
      S_DRY: begin cmd.op = OP_DRY; state_nxt = S_WET; end
      S_WET: begin cmd.op = OP_WET; state_nxt = S_MIX; end
      S_MIX: begin cmd.op = OP_MIX; state_nxt = S_DONE; end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `HSE_ASSERT_IMP(a_emit_slot_free, clk, rst_n, cmd.emit, !out_valid_r || out_ready)
  `HSE_ASSERT_IMP(a_div_count, clk, rst_n, state_r == S_DIV, cnt_r < CNT_W'(DIV_STEPS))
  `HSE_ASSERT_NXT(a_busy_after_beat, clk, rst_n, in_valid && in_ready, !in_ready)
  `HSE_ASSERT_NXT(a_emit_sets_valid, clk, rst_n, cmd.emit, out_valid_r)

endmodule
`default_nettype wire

// ----- sim/highpass_saturation_exciter_tb.sv -----
// self-checking testbench of the high-pass saturation exciter
`timescale 1ns / 1ps
`default_nettype none

class exciter_scoreboard;
  localparam longint S32_LO = -64'sd2147483648;
  localparam longint S32_HI = 64'sd2147483647;

  bit               ena;
  logic signed [31:0] b0, a1, a2;
  logic [23:0]      drive;
  logic [16:0]      wet;
  logic signed [31:0] z1s [2];
  logic signed [31:0] z2s [2];
  logic [23:0]      pending [$];
  int               errors;

  function new();
    ena = 0; b0 = 32'sd268435456; a1 = 0; a2 = 0; drive = 24'd65536; wet = 0;
    z1s = '{0, 0}; z2s = '{0, 0}; errors = 0;
  endfunction

  function void write_reg(int idx, logic [31:0] v);
    case (idx)
      hse_pkg::REG_ENABLE: ena = v[0];
      hse_pkg::REG_B0:     b0 = v;
      hse_pkg::REG_A1:     a1 = v;
      hse_pkg::REG_A2:     a2 = v;
      hse_pkg::REG_DRIVE:  drive = v[23:0];
      hse_pkg::REG_WET:    wet = v[16:0];
      default: ;
    endcase
  endfunction

  function longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function void note_beat(logic opc, logic ch, logic signed [23:0] smp);
    longint x, bx, hp, n1, n2, d, e, x2, w, m;
    x = smp;
    if (opc == hse_pkg::OPC_CLEAR) begin
      z1s = '{0, 0}; z2s = '{0, 0};
      pending.push_back(24'd0);
      return;
    end
    if (!ena) begin
      pending.push_back(smp);
      return;
    end
    bx = longint'(b0) * x;
    hp = clip(rnd_shift(bx, 28) + z1s[ch], S32_LO, S32_HI);
    n1 = clip(rnd_shift(-2 * bx - longint'(a1) * hp, 28) + z2s[ch], S32_LO, S32_HI);
    n2 = clip(rnd_shift(bx - longint'(a2) * hp, 28), S32_LO, S32_HI);
    z1s[ch] = n1; z2s[ch] = n2;
    d = rnd_shift(hp * longint'(drive), 16);
    if (d > 3 * 8388608) e = 8388608;
    else if (d < -3 * 8388608) e = -8388608;
    else begin
      x2 = rnd_shift(d * d, 23);
      e = (d * (27 * 8388608 + x2)) / (27 * 8388608 + 9 * x2);
    end
    w = wet > 65536 ? 65536 : wet;
    m = clip(rnd_shift(x * (65536 - w) + e * w, 16), -8388608, 8388607);
    pending.push_back(m[23:0]);
  endfunction

  function void check_beat(logic [23:0] got);
    logic [23:0] want;
    if (pending.size() == 0) begin
      $display("%0t unexpected beat: expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (want !== got) begin
      $display("%0t sample_out mismatch: expected %h, actual %h", $time, want, got);
      errors++;
    end
  endfunction
endclass

module highpass_saturation_exciter_tb;
  import hse_pkg::*;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 0, in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;   // opcode, channel
  logic out_tvalid, out_tready = 0;
  logic [23:0] out_tdata;     // sample_out

  exciter_scoreboard sb = new();
  bit calm = 0;
  int idle_cycles = 0;
  bit timed_out = 0;

  highpass_saturation_exciter dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (in_tvalid && in_tready) sb.note_beat(in_tuser[0], in_tuser[1], in_tdata);
    if (out_tvalid && out_tready) sb.check_beat(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    out_tready <= calm || ($urandom_range(99) >= 25);
    if (idle_cycles > 20000 && !timed_out) begin
      timed_out = 1;
      $display("highpass_saturation_exciter regression: fail");
      $finish;
    end
  end

  task automatic write_reg(int idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= CFG_IDX_W'(idx); cfg_wdata <= v;
    sb.write_reg(idx, v);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_beat(logic opc, logic ch, logic [23:0] smp);
    while (!calm && $urandom_range(99) < 25) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1; in_tuser <= {ch, opc}; in_tdata <= smp;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    @(posedge clk);
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'($urandom_range(255) - 128);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) begin
      calm = (i % 200) > 160;
      send_beat($urandom_range(29) == 0 ? OPC_CLEAR : OPC_PROCESS, 1'($urandom_range(1)),
                rand_sample());
    end
    calm = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    // directed: disabled pass-through and clear
    send_beat(OPC_PROCESS, 1'b0, 24'h7fffff);
    send_beat(OPC_PROCESS, 1'b1, 24'h800000);
    send_beat(OPC_CLEAR, 1'b0, 24'h123456);
    drain();
    write_reg(REG_ENABLE, 1);
    write_reg(REG_WET, 65536);
    write_reg(7, 32'hdeadbeef);
    send_beat(OPC_PROCESS, 1'b0, 24'h7fffff);
    send_beat(OPC_PROCESS, 1'b1, 24'h800000);
    send_beat(OPC_PROCESS, 1'b0, 24'h000000);
    send_beat(OPC_PROCESS, 1'b1, 24'h000001);
    send_beat(OPC_CLEAR, 1'b1, 24'hffffff);
    send_beat(OPC_PROCESS, 1'b0, 24'h400000);
    drain();
    write_reg(REG_DRIVE, 32'h00ffffff);
    write_reg(REG_B0, 32'h7fffffff);
    write_reg(REG_A1, 32'h80000000);
    write_reg(REG_A2, 32'h7fffffff);
    write_reg(REG_WET, 32'h0001ffff);
    send_beat(OPC_PROCESS, 1'b0, 24'h7fffff);
    send_beat(OPC_PROCESS, 1'b0, 24'h800000);
    send_beat(OPC_PROCESS, 1'b1, 24'h000100);
    send_beat(OPC_PROCESS, 1'b1, 24'hffff00);
    send_beat(OPC_CLEAR, 1'b0, 24'h0);
    drain();
    // second-order high-pass coefficients, moderate drive, half mix
    write_reg(REG_B0, 32'd250000000);
    write_reg(REG_A1, -32'sd500000000);
    write_reg(REG_A2, 32'd120000000);
    write_reg(REG_DRIVE, 32'd262144);
    write_reg(REG_WET, 32'd32768);
    random_run(250);
    drain();
    write_reg(REG_B0, $urandom);
    write_reg(REG_A1, $urandom);
    write_reg(REG_A2, $urandom);
    write_reg(REG_DRIVE, $urandom);
    write_reg(REG_WET, $urandom_range(65536));
    random_run(200);
    drain();
    write_reg(REG_DRIVE, 32'd0);
    write_reg(REG_WET, 32'd0);
    random_run(60);
    drain();
    write_reg(REG_ENABLE, 0);
    random_run(60);
    drain();
    write_reg(REG_ENABLE, 1);
    write_reg(REG_B0, 32'h80000000);
    write_reg(REG_DRIVE, 32'd1000);
    write_reg(REG_WET, 32'd50000);
    random_run(120);
    drain();
    if (sb.errors == 0)
      $display("highpass_saturation_exciter regression: pass");
    else
      $display("highpass_saturation_exciter regression: fail");
    $finish;
  end
endmodule

`default_nettype wire

// ----- highpass_saturation_exciter.f -----
+incdir+sv
sv/hse_pkg.sv
sv/hse_dp.sv
sv/hse_ctrl.sv
sv/highpass_saturation_exciter.sv
sim/highpass_saturation_exciter_tb.sv
